FILE: rtl/scs_pkg.sv
package scs_pkg;

    localparam int SLOT_FIELD_W = 5;
    localparam int CFG_W        = 6;
    localparam int OUT_TDATA_W  = 16;
    localparam int OUT_PAD_W    = OUT_TDATA_W - 2 * SLOT_FIELD_W - 3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    localparam logic [1:0] ST_OUT   = 2'd0;
    localparam logic [1:0] ST_ENTER = 2'd1;
    localparam logic [1:0] ST_STAY  = 2'd2;
    localparam logic [1:0] ST_EXIT  = 2'd3;

    typedef struct packed {
        logic vld;
        logic is_self;
    } scs_pair_ctl_t;

    typedef struct packed {
        logic vld;
        logic hit;
    } scs_pair_res_t;

    function automatic logic [1:0] contact_next(input logic [1:0] cur, input logic hit);
        logic [1:0] nxt;
        if (hit)
        begin
            case (cur) inside
                ST_OUT, ST_EXIT: nxt = ST_ENTER;
                default:         nxt = ST_STAY;
            endcase
        end
        else
        begin
            case (cur) inside
                ST_ENTER, ST_STAY: nxt = ST_EXIT;
                default:           nxt = ST_OUT;
            endcase
        end
        return nxt;
    endfunction

endpackage

FILE: rtl/sphere_contact_tracker.sv
// sphere_contact_tracker
//
// Input stream (s_*): one word per item. s_tuser = func (load or step).
// A load word writes one sphere slot. A step word tests each active slot
// against active slots in slot order up to the first overlap and emits
// one result word per active slot on m_*, m_tlast on the final one. Write
// active_count via cfg_we / cfg_wdata only while idle; it is not enforced.
//
// Steps of a step word, per active slot: S_RDI and S_LATI fetch the slot
// and its contact state, then one sphere memory read per cycle through the
// issue register into a 4-stage pair test pipeline until the first overlap
// or the last slot resolves, then S_OUT posts the result. The single read
// port of the sphere memory sets the pair rate.
// The result register lets the block take the next word while a result
// waits; a stalled m_tready holds the step before its next result.
// Reset clears the contact states of all slots and active_count; sphere
// data is undefined until loaded.
module sphere_contact_tracker
    import scs_pkg::*;
#(
    parameter int MAX_SPHERES = 32,
    parameter int COORD_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_W-1:0]        cfg_wdata,     // active_count
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // slot, pos_x, pos_y, pos_z, radius from the lowest bit up, zero filled
    input  logic [((SLOT_FIELD_W + 4*COORD_WIDTH + 7) / 8) * 8 - 1 : 0] s_tdata,
    input  logic                    s_tuser,       // func
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // sphere_slot, contact_state, hit, partner_slot from the lowest bit up
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    output logic                    m_tlast        // last
);

    localparam int SLOT_W = $clog2(MAX_SPHERES);
    localparam int CNT_W  = $clog2(MAX_SPHERES + 1);
    localparam int SPH_W  = 4 * COORD_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDI  = 3'd1;
    localparam logic [2:0] S_LATI = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [SPH_W-1:0]        sph_mem [MAX_SPHERES];
    logic [1:0]              ct_mem  [MAX_SPHERES];

    logic [2:0]              state_reg, state_next;
    logic [CFG_W-1:0]        active_reg;
    logic [CNT_W-1:0]        n_reg, n_next, n_sat;
    logic [SLOT_W-1:0]       i_reg, i_next;
    logic [SLOT_W-1:0]       last_idx_reg, last_idx_next;
    logic [CNT_W-1:0]        j_reg, j_next;
    logic                    iss_vld_reg, iss_vld_next;
    logic                    iss_self_reg, iss_self_next;
    logic [SLOT_W-1:0]       iss_idx_reg, iss_idx_next;
    logic [SPH_W-1:0]        sph_rd_reg;
    logic [SPH_W-1:0]        a_reg, a_next;
    logic [1:0]              ct_rd_reg;
    logic                    ct_rd_vld_reg;
    logic [MAX_SPHERES-1:0]  ct_vld_reg;
    logic                    dec_hit_reg, dec_hit_next;
    logic [SLOT_W-1:0]       dec_partner_reg, dec_partner_next;
    logic [1:0]              dec_state_reg, dec_state_next;
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;
    logic                    out_last_reg;

    logic                    s_acc;
    logic [SLOT_FIELD_W-1:0] in_slot;
    logic                    sph_we;
    logic [SLOT_W-1:0]       rd_addr;
    logic [1:0]              cur_state;
    logic                    ct_we;
    logic                    flush;
    logic                    decide;
    logic                    out_load;

    scs_pair_ctl_t           pr_ctl;
    scs_pair_res_t           pr_res;
    logic [SLOT_W-1:0]       pr_idx;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign in_slot  = s_tdata[SLOT_FIELD_W-1:0];
    assign sph_we   = s_acc && (s_tuser == FUNC_LOAD) && (int'(in_slot) < MAX_SPHERES);
    assign rd_addr  = (state_reg == S_RDI) ? i_reg : j_reg[SLOT_W-1:0];
    assign cur_state = ct_rd_vld_reg ? ct_rd_reg : ST_OUT;
    assign decide   = (state_reg == S_SCAN) && pr_res.vld
                      && (pr_res.hit || (pr_idx == last_idx_reg));

    always_comb
    begin
        if (int'(active_reg) > MAX_SPHERES)
            n_sat = CNT_W'(MAX_SPHERES);
        else
            n_sat = CNT_W'(active_reg);
    end

    always_ff @(posedge clk)
    begin
        if (sph_we)
            sph_mem[SLOT_W'(in_slot)] <= s_tdata[SLOT_FIELD_W +: SPH_W];
        sph_rd_reg <= sph_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ct_we)
            ct_mem[i_reg] <= dec_state_next;
        ct_rd_reg <= ct_mem[i_reg];
    end

    always_comb
    begin
        state_next       = state_reg;
        n_next           = n_reg;
        i_next           = i_reg;
        last_idx_next    = last_idx_reg;
        j_next           = j_reg;
        iss_vld_next     = 1'b0;
        iss_self_next    = iss_self_reg;
        iss_idx_next     = iss_idx_reg;
        a_next           = a_reg;
        dec_hit_next     = dec_hit_reg;
        dec_partner_next = dec_partner_reg;
        dec_state_next   = dec_state_reg;
        ct_we            = 1'b0;
        flush            = 1'b0;
        out_load         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc && (s_tuser == FUNC_STEP) && (n_sat != '0))
                begin
                    n_next        = n_sat;
                    last_idx_next = SLOT_W'(n_sat - 1'b1);
                    i_next        = '0;
                    state_next    = S_RDI;
                end
            end
            S_RDI:
            begin
                state_next = S_LATI;
            end
            S_LATI:
            begin
                a_next     = sph_rd_reg;
                j_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (decide)
                begin
                    flush            = 1'b1;
                    dec_hit_next     = pr_res.hit;
                    dec_partner_next = pr_res.hit ? pr_idx : '0;
                    dec_state_next   = contact_next(cur_state, pr_res.hit);
                    ct_we            = 1'b1;
                    state_next       = S_OUT;
                end
                else if (j_reg < n_reg)
                begin
                    iss_vld_next  = 1'b1;
                    iss_idx_next  = j_reg[SLOT_W-1:0];
                    iss_self_next = (j_reg[SLOT_W-1:0] == i_reg);
                    j_next        = j_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load = 1'b1;
                    if (i_reg == last_idx_reg)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_RDI;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            last_idx_reg  <= '0;
            j_reg         <= '0;
            iss_vld_reg   <= 1'b0;
            ct_vld_reg    <= '0;
            ct_rd_vld_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            last_idx_reg  <= last_idx_next;
            j_reg         <= j_next;
            iss_vld_reg   <= iss_vld_next;
            ct_rd_vld_reg <= ct_vld_reg[i_reg];
            if (cfg_we)
                active_reg <= cfg_wdata;
            if (ct_we)
                ct_vld_reg[i_reg] <= 1'b1;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_self_reg    <= iss_self_next;
        iss_idx_reg     <= iss_idx_next;
        a_reg           <= a_next;
        dec_hit_reg     <= dec_hit_next;
        dec_partner_reg <= dec_partner_next;
        dec_state_reg   <= dec_state_next;
        if (out_load)
        begin
            out_data_reg <= {OUT_PAD_W'(0), SLOT_FIELD_W'(dec_partner_reg), dec_hit_reg,
                             dec_state_reg, SLOT_FIELD_W'(i_reg)};
            out_last_reg <= (i_reg == last_idx_reg);
        end
    end

    assign pr_ctl.vld     = iss_vld_reg;
    assign pr_ctl.is_self = iss_self_reg;

    scs_pair_test #(
        .COORD_WIDTH (COORD_WIDTH),
        .SLOT_W      (SLOT_W)
    ) u_pair_test (
        .clk     (clk),
        .rst_n   (rst_n),
        .flush   (flush),
        .in_ctl  (pr_ctl),
        .in_idx  (iss_idx_reg),
        .sph_a   (a_reg),
        .sph_b   (sph_rd_reg),
        .res     (pr_res),
        .res_idx (pr_idx)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && m_tvalid && !m_tready) |=> (state_reg == S_OUT))
        else $error("result register overwritten while stalled");

    a_state_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7]
                      ? (m_tdata[6:5] == ST_ENTER || m_tdata[6:5] == ST_STAY)
                      : ((m_tdata[6:5] == ST_OUT || m_tdata[6:5] == ST_EXIT)
                         && m_tdata[12:8] == '0)))
        else $error("contact state disagrees with hit");

    a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
        iss_vld_reg |-> (CNT_W'(iss_idx_reg) < n_reg))
        else $error("pair issued beyond active slots");

    a_pipe_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDI || state_reg == S_LATI) |-> !pr_res.vld)
        else $error("stale pair result after decision");

endmodule

FILE: rtl/scs_pair_test.sv
module scs_pair_test
    import scs_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int SLOT_W      = 5
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       flush,
    input  scs_pair_ctl_t              in_ctl,
    input  logic [SLOT_W-1:0]          in_idx,
    input  logic [4*COORD_WIDTH-1:0]   sph_a,    // x, y, z, radius from the lowest bit up
    input  logic [4*COORD_WIDTH-1:0]   sph_b,
    output scs_pair_res_t              res,
    output logic [SLOT_W-1:0]          res_idx
);

    localparam int CW    = COORD_WIDTH;
    localparam int SQ_W  = 2 * CW;
    localparam int SUM_W = 2 * CW + 2;

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] d;
        logic [CW:0] nd;
        d  = {b[CW-1], b} - {a[CW-1], a};
        nd = -d;
        return d[CW] ? nd[CW-1:0] : d[CW-1:0];
    endfunction

    scs_pair_ctl_t     s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic [SLOT_W-1:0] s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic              s4_vld_reg, s4_hit_reg;

    logic [CW-1:0]     dx_reg, dy_reg, dz_reg;
    logic [CW:0]       rs_reg;
    logic [SQ_W-1:0]   sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0]  r2_reg, r2b_reg, sum_reg;

    logic [SQ_W-1:0]   sqx_next, sqy_next, sqz_next;
    logic [SUM_W-1:0]  r2_next, sum_next;
    logic [CW:0]       rs_next;

    assign rs_next  = {1'b0, sph_a[3*CW +: CW]} + {1'b0, sph_b[3*CW +: CW]};
    assign sqx_next = dx_reg * dx_reg;
    assign sqy_next = dy_reg * dy_reg;
    assign sqz_next = dz_reg * dz_reg;
    assign r2_next  = rs_reg * rs_reg;
    assign sum_next = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_vld_reg <= 1'b0;
        end
        else if (flush)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_ctl_reg <= in_ctl;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_vld_reg <= s3_ctl_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: differences and radius sum
        s1_idx_reg <= in_idx;
        dx_reg     <= abs_diff(sph_a[0 +: CW], sph_b[0 +: CW]);
        dy_reg     <= abs_diff(sph_a[CW +: CW], sph_b[CW +: CW]);
        dz_reg     <= abs_diff(sph_a[2*CW +: CW], sph_b[2*CW +: CW]);
        rs_reg     <= rs_next;
        // stage 2: squares
        s2_idx_reg <= s1_idx_reg;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        sqz_reg    <= sqz_next;
        r2_reg     <= r2_next;
        // stage 3: distance sum
        s3_idx_reg <= s2_idx_reg;
        sum_reg    <= sum_next;
        r2b_reg    <= r2_reg;
        // stage 4: compare
        s4_idx_reg <= s3_idx_reg;
        s4_hit_reg <= !s3_ctl_reg.is_self && (sum_reg < r2b_reg);
    end

    assign res.vld = s4_vld_reg;
    assign res.hit = s4_hit_reg;
    assign res_idx = s4_idx_reg;

endmodule
